[src/ngh_pkg.sv]
// Package for the noise gate with hold and punch: widths, fixed-point constants,
// register map codes and the structs shared by the config block, controller and datapath.
// No dependencies.
package ngh_pkg;

  localparam int CHANNELS    = 2;
  localparam int CH_BITS     = 1;
  localparam int SAMPLE_BITS = 24;
  localparam int ENV_W       = 24;
  localparam int GAIN_W      = 24;
  localparam int COEFF_W     = 24;
  localparam int FLOOR_W     = 23;
  localparam int HOLD_W      = 16;
  localparam int MIX_W       = 17;
  localparam int WET_W       = SAMPLE_BITS + 2;
  localparam int MUL_A_W     = SAMPLE_BITS + 3;
  localparam int MUL_B_W     = GAIN_W + 1;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int K_W         = 18;
  localparam int APB_AW      = 5;
  localparam int APB_DW      = 32;

  localparam logic [GAIN_W-1:0] UNITY_GAIN       = 24'd4194304;
  localparam logic [K_W-1:0]    GLIDE_K          = 18'd167772;
  localparam logic [K_W-1:0]    DECAY_K          = 18'd50332;
  localparam logic [MIX_W-1:0]  MIX_FULL         = 17'd65536;
  localparam logic [MIX_W-1:0]  MIX_BYPASS_LIMIT = 17'd65470;

  localparam logic [COEFF_W-1:0] RST_ATTACK  = 24'd16603400;
  localparam logic [COEFF_W-1:0] RST_RELEASE = 24'd16774300;
  localparam logic [ENV_W-1:0]   RST_OPEN    = 24'd265271;
  localparam logic [ENV_W-1:0]   RST_CLOSE   = 24'd187826;
  localparam logic [FLOOR_W-1:0] RST_FLOOR   = 23'd132635;
  localparam logic [HOLD_W-1:0]  RST_HOLD    = 16'd960;
  localparam logic [GAIN_W-1:0]  RST_PUNCH   = 24'd6647668;
  localparam logic [MIX_W-1:0]   RST_MIX     = 17'd65536;

  typedef enum logic [2:0] {
    REG_ATTACK,
    REG_RELEASE,
    REG_OPEN,
    REG_CLOSE,
    REG_FLOOR,
    REG_HOLD,
    REG_PUNCH,
    REG_MIX
  } ngh_reg_e;

  typedef struct packed {
    logic [COEFF_W-1:0] attack_coeff;
    logic [COEFF_W-1:0] release_coeff;
    logic [ENV_W-1:0]   open_threshold;
    logic [ENV_W-1:0]   close_threshold;
    logic [FLOOR_W-1:0] floor_gain;
    logic [HOLD_W-1:0]  hold_length;
    logic [GAIN_W-1:0]  punch_gain;
    logic [MIX_W-1:0]   mix_amount;
  } ngh_cfg_t;

  typedef struct packed {
    logic latch;
    logic glide;
    logic env;
    logic gate;
    logic wet;
    logic decay;
    logic mix;
    logic load_out;
  } ngh_cmd_t;

  typedef struct packed {
    logic out_free;
  } ngh_sts_t;

endpackage

[src/ngh_if.sv]
// Stream interfaces for the noise gate: input beat (channel, audio, key) and
// result beat (channel, gated sample, gain). Depends on ngh_pkg.
interface ngh_in_if;
  import ngh_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [CH_BITS-1:0]            channel_index;
  logic signed [SAMPLE_BITS-1:0] audio_sample;
  logic signed [SAMPLE_BITS-1:0] key_sample;

  modport source (output valid, channel_index, audio_sample, key_sample, input ready);
  modport sink   (input valid, channel_index, audio_sample, key_sample, output ready);
endinterface

interface ngh_out_if;
  import ngh_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [CH_BITS-1:0]            channel_out;
  logic signed [SAMPLE_BITS-1:0] gated_sample;
  logic [GAIN_W-1:0]             gate_gain;

  modport source (output valid, channel_out, gated_sample, gate_gain, input ready);
  modport sink   (input valid, channel_out, gated_sample, gate_gain, output ready);
endinterface

[src/ngh_regs.sv]
// APB-style configuration registers of the noise gate, with readback.
// Depends on ngh_pkg.
module ngh_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ngh_pkg::APB_AW-1:0]  paddr,
  input  logic [ngh_pkg::APB_DW-1:0]  pwdata,
  output logic [ngh_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output ngh_pkg::ngh_cfg_t           cfg_o
);
  import ngh_pkg::*;

  ngh_cfg_t cfg_q;
  ngh_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = ngh_reg_e'(paddr[APB_AW-1:2]);
  assign wr_en   = psel & penable & pwrite;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_coeff    <= RST_ATTACK;
      cfg_q.release_coeff   <= RST_RELEASE;
      cfg_q.open_threshold  <= RST_OPEN;
      cfg_q.close_threshold <= RST_CLOSE;
      cfg_q.floor_gain      <= RST_FLOOR;
      cfg_q.hold_length     <= RST_HOLD;
      cfg_q.punch_gain      <= RST_PUNCH;
      cfg_q.mix_amount      <= RST_MIX;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_ATTACK:  cfg_q.attack_coeff    <= pwdata[COEFF_W-1:0];
        REG_RELEASE: cfg_q.release_coeff   <= pwdata[COEFF_W-1:0];
        REG_OPEN:    cfg_q.open_threshold  <= pwdata[ENV_W-1:0];
        REG_CLOSE:   cfg_q.close_threshold <= pwdata[ENV_W-1:0];
        REG_FLOOR:   cfg_q.floor_gain      <= pwdata[FLOOR_W-1:0];
        REG_HOLD:    cfg_q.hold_length     <= pwdata[HOLD_W-1:0];
        REG_PUNCH:   cfg_q.punch_gain      <= pwdata[GAIN_W-1:0];
        REG_MIX:     cfg_q.mix_amount      <= pwdata[MIX_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ATTACK:  prdata = APB_DW'(cfg_q.attack_coeff);
      REG_RELEASE: prdata = APB_DW'(cfg_q.release_coeff);
      REG_OPEN:    prdata = APB_DW'(cfg_q.open_threshold);
      REG_CLOSE:   prdata = APB_DW'(cfg_q.close_threshold);
      REG_FLOOR:   prdata = APB_DW'(cfg_q.floor_gain);
      REG_HOLD:    prdata = APB_DW'(cfg_q.hold_length);
      REG_PUNCH:   prdata = APB_DW'(cfg_q.punch_gain);
      REG_MIX:     prdata = APB_DW'(cfg_q.mix_amount);
    endcase
  end

endmodule

[src/ngh_ctrl.sv]
// Sequencer of the noise gate: steps one beat through glide, envelope, gate,
// wet, decay, mix and output load. Depends on ngh_pkg.
module ngh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ngh_pkg::ngh_sts_t sts_i,
  output ngh_pkg::ngh_cmd_t cmd_o
);
  import ngh_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GLIDE,
    ST_ENV,
    ST_GATE,
    ST_WET,
    ST_DECAY,
    ST_MIX,
    ST_OUT
  } state_e;

  state_e state_q;
  logic   in_fire;
  logic   out_load;

  assign out_load   = (state_q == ST_OUT) && sts_i.out_free;
  assign in_ready_o = (state_q == ST_IDLE) || out_load;
  assign in_fire    = in_valid_i && in_ready_o;

  assign cmd_o.latch    = in_fire;
  assign cmd_o.glide    = (state_q == ST_GLIDE);
  assign cmd_o.env      = (state_q == ST_ENV);
  assign cmd_o.gate     = (state_q == ST_GATE);
  assign cmd_o.wet      = (state_q == ST_WET);
  assign cmd_o.decay    = (state_q == ST_DECAY);
  assign cmd_o.mix      = (state_q == ST_MIX);
  assign cmd_o.load_out = out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE:  if (in_fire) state_q <= ST_GLIDE;
        ST_GLIDE: state_q <= ST_ENV;
        ST_ENV:   state_q <= ST_GATE;
        ST_GATE:  state_q <= ST_WET;
        ST_WET:   state_q <= ST_DECAY;
        ST_DECAY: state_q <= ST_MIX;
        ST_MIX:   state_q <= ST_OUT;
        ST_OUT: begin
          if (in_fire) begin
            state_q <= ST_GLIDE;
          end else if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  a_steps_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.glide, cmd_o.env, cmd_o.gate, cmd_o.wet, cmd_o.decay, cmd_o.mix,
              cmd_o.load_out}))
    else $error("more than one datapath step active");

  a_glide_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.glide |-> $past(cmd_o.latch))
    else $error("glide step without a preceding accepted beat");

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (sts_i.out_free && $past(cmd_o.mix) || $past(state_q == ST_OUT)))
    else $error("result loaded out of sequence or over a pending beat");

endmodule

[src/ngh_dp.sv]
// Datapath of the noise gate: per-channel envelope, hold and gain state, one shared
// signed multiplier with product register, and the result register. Depends on ngh_pkg.
module ngh_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ngh_pkg::ngh_cmd_t                   cmd_i,
  output ngh_pkg::ngh_sts_t                   sts_o,
  input  ngh_pkg::ngh_cfg_t                   cfg_i,
  input  logic [ngh_pkg::CH_BITS-1:0]         channel_index_i,
  input  logic signed [ngh_pkg::SAMPLE_BITS-1:0] audio_sample_i,
  input  logic signed [ngh_pkg::SAMPLE_BITS-1:0] key_sample_i,
  ngh_out_if.source                           out_o
);
  import ngh_pkg::*;

  localparam logic signed [PROD_W-1:0] HALF_24  = PROD_W'(2**23);
  localparam logic signed [PROD_W-1:0] HALF_22  = PROD_W'(2**21);
  localparam logic signed [PROD_W-1:0] HALF_22M = PROD_W'(2**21 - 1);
  localparam logic signed [PROD_W-1:0] HALF_16  = PROD_W'(2**15);
  localparam logic signed [PROD_W-1:0] HALF_16M = PROD_W'(2**15 - 1);
  localparam logic signed [PROD_W-1:0] SAT_HI   = PROD_W'(2**(SAMPLE_BITS-1) - 1);
  localparam logic signed [PROD_W-1:0] SAT_LO   = ~SAT_HI;

  // per-channel state
  logic [ENV_W-1:0]  env_q  [CHANNELS];
  logic [HOLD_W-1:0] hold_q [CHANNELS];
  logic [GAIN_W-1:0] gstate_q [CHANNELS];

  // beat registers
  logic [CH_BITS-1:0]            ch_q;
  logic signed [SAMPLE_BITS-1:0] dry_q;
  logic [ENV_W-1:0]              level_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic [GAIN_W-1:0]             glide_step_q;
  logic [GAIN_W-1:0]             gain_q;
  logic signed [WET_W-1:0]       wet_q;

  // result register
  logic                          out_valid_q;
  logic [CH_BITS-1:0]            out_ch_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic [GAIN_W-1:0]             out_gain_q;

  logic [SAMPLE_BITS-1:0]        key_mag;
  logic [ENV_W-1:0]              env_old;
  logic [HOLD_W-1:0]             hold_old;
  logic [GAIN_W-1:0]             gain_old;
  logic [GAIN_W-1:0]             floor_ext;
  logic                          floor_up;
  logic [GAIN_W-1:0]             glide_diff;
  logic signed [ENV_W:0]         env_diff;
  logic [COEFF_W-1:0]            coeff;
  logic [MIX_W-1:0]              mix_m;
  logic                          bypass;
  logic                          gain_over;

  logic signed [MUL_A_W-1:0]     mul_a;
  logic signed [MUL_B_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]      mul_p;

  logic signed [PROD_W-1:0]      rnd24;
  logic signed [PROD_W-1:0]      rnd24_sh;
  logic [GAIN_W-1:0]             step24;
  logic signed [ENV_W+2:0]       env_sum;
  logic [ENV_W-1:0]              env_new;
  logic [HOLD_W-1:0]             hold_nxt;
  logic [GAIN_W-1:0]             gain_nxt;

  logic signed [PROD_W-1:0]      wet_sh;
  logic signed [PROD_W-1:0]      blend;
  logic signed [PROD_W-1:0]      blend_sh;
  logic signed [PROD_W-1:0]      res_full;
  logic signed [SAMPLE_BITS-1:0] res;

  assign key_mag    = key_sample_i[SAMPLE_BITS-1] ? (~key_sample_i + 1'b1) : key_sample_i;
  assign env_old    = env_q[ch_q];
  assign hold_old   = hold_q[ch_q];
  assign gain_old   = gstate_q[ch_q];
  assign floor_ext  = GAIN_W'(cfg_i.floor_gain);
  assign floor_up   = floor_ext >= gain_old;
  assign glide_diff = floor_up ? (floor_ext - gain_old) : (gain_old - floor_ext);
  assign env_diff   = $signed({1'b0, env_old}) - $signed({1'b0, level_q});
  assign coeff      = (level_q > env_old) ? cfg_i.attack_coeff : cfg_i.release_coeff;
  assign mix_m      = (cfg_i.mix_amount > MIX_FULL) ? MIX_FULL : cfg_i.mix_amount;
  assign bypass     = mix_m > MIX_BYPASS_LIMIT;
  assign gain_over  = gain_q > UNITY_GAIN;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique if (cmd_i.glide) begin
      mul_a = $signed(MUL_A_W'(GLIDE_K));
      mul_b = $signed(MUL_B_W'(glide_diff));
    end else if (cmd_i.env) begin
      mul_a = MUL_A_W'(env_diff);
      mul_b = $signed(MUL_B_W'(coeff));
    end else if (cmd_i.wet) begin
      mul_a = MUL_A_W'(dry_q);
      mul_b = $signed(MUL_B_W'(gain_q));
    end else if (cmd_i.decay) begin
      mul_a = $signed(MUL_A_W'(DECAY_K));
      mul_b = gain_over ? $signed(MUL_B_W'(gain_q - UNITY_GAIN)) : '0;
    end else if (cmd_i.mix) begin
      mul_a = MUL_A_W'(wet_q) - MUL_A_W'(dry_q);
      mul_b = $signed(MUL_B_W'(mix_m));
    end else begin
      mul_a = '0;
      mul_b = '0;
    end
  end

  assign mul_p = mul_a * mul_b;

  // Q24 rounding for glide, decay and envelope
  assign rnd24    = prod_q + HALF_24;
  assign rnd24_sh = rnd24 >>> 24;
  assign step24   = rnd24[GAIN_W+23:24];
  assign env_sum  = $signed({3'b000, level_q}) + $signed(rnd24_sh[ENV_W+2:0]);
  assign env_new  = (|env_sum[ENV_W+2:ENV_W]) ? '1 : env_sum[ENV_W-1:0];

  always_comb begin
    hold_nxt = hold_old;
    gain_nxt = gain_old;
    if (env_new >= cfg_i.open_threshold) begin
      hold_nxt = cfg_i.hold_length;
      gain_nxt = cfg_i.punch_gain;
    end else if (hold_old != '0) begin
      hold_nxt = hold_old - 1'b1;
    end else if (env_new <= cfg_i.close_threshold) begin
      gain_nxt = floor_up ? (gain_old + glide_step_q) : (gain_old - glide_step_q);
    end
  end

  // round half away from zero
  assign wet_sh   = (prod_q + (prod_q[PROD_W-1] ? HALF_22M : HALF_22)) >>> 22;
  assign blend    = (PROD_W'(dry_q) <<< 16) + prod_q;
  assign blend_sh = (blend + (blend[PROD_W-1] ? HALF_16M : HALF_16)) >>> 16;
  assign res_full = bypass ? PROD_W'(wet_q) : blend_sh;

  always_comb begin
    if (res_full > SAT_HI) begin
      res = SAT_HI[SAMPLE_BITS-1:0];
    end else if (res_full < SAT_LO) begin
      res = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      res = res_full[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        env_q[i]    <= '0;
        hold_q[i]   <= '0;
        gstate_q[i] <= UNITY_GAIN;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.gate) begin
        env_q[ch_q]  <= env_new;
        hold_q[ch_q] <= hold_nxt;
      end
      if (cmd_i.mix) begin
        gstate_q[ch_q] <= gain_q - step24;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      ch_q    <= channel_index_i;
      dry_q   <= audio_sample_i;
      level_q <= ENV_W'(key_mag);
    end
    if (cmd_i.glide || cmd_i.env || cmd_i.wet || cmd_i.decay || cmd_i.mix) begin
      prod_q <= mul_p;
    end
    if (cmd_i.env) begin
      glide_step_q <= step24;
    end
    if (cmd_i.gate) begin
      gain_q <= gain_nxt;
    end
    if (cmd_i.decay) begin
      wet_q <= wet_sh[WET_W-1:0];
    end
    if (cmd_i.load_out) begin
      out_ch_q     <= ch_q;
      out_sample_q <= res;
      out_gain_q   <= gain_q;
    end
  end

  assign sts_o.out_free     = !out_valid_q || out_o.ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.channel_out  = out_ch_q;
  assign out_o.gated_sample = out_sample_q;
  assign out_o.gate_gain    = out_gain_q;

endmodule

[src/noise_gate_hold_punch_top.sv]
// Top level of the two-channel noise gate with hold, hysteresis and punch.
// Depends on ngh_pkg, ngh_if, ngh_regs, ngh_ctrl and ngh_dp.
//
// One result beat follows each input beat, in order. From acceptance to its
// result being loaded into the output register, a beat passes through six
// sequenced steps (gain glide, envelope, gate decision, wet product, gain
// decay, dry/wet blend), all but the gate decision on one shared 27x25 signed
// multiplier with a registered product, then the output load, and the next
// beat is accepted in the same cycle the result is loaded, so no new beat is
// taken while an earlier one is still in its sequenced steps. A finished
// result waits in the output register; a new beat is taken in the meantime
// and held back only at its final load. No clearing pass after reset. Write
// configuration only while no beat is in flight.
module noise_gate_hold_punch_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ngh_in_if.sink                      in_i,
  ngh_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ngh_pkg::APB_AW-1:0]  paddr,
  input  logic [ngh_pkg::APB_DW-1:0]  pwdata,
  output logic [ngh_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import ngh_pkg::*;

  ngh_cfg_t cfg;
  ngh_cmd_t cmd;
  ngh_sts_t sts;
  logic     in_ready;

  assign in_i.ready = in_ready;

  ngh_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ngh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ngh_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_i           (cfg),
    .channel_index_i (in_i.channel_index),
    .audio_sample_i  (in_i.audio_sample),
    .key_sample_i    (in_i.key_sample),
    .out_o           (out_o)
  );

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for noise_gate_hold_punch_top: directed and random beats with
// random valid/ready gaps, APB register phases and a bit-exact gate tracker class.
// Depends on ngh_pkg, ngh_if and the gate RTL.
module testbench;
  import ngh_pkg::*;

  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 78;
  localparam int SETTLE_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT  = 2000;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct {
    logic [CH_BITS-1:0]     chan;
    logic [SAMPLE_BITS-1:0] sample;
    logic [GAIN_W-1:0]      gain;
  } gated_beat_t;

  class gate_tracker;
    ngh_cfg_t    cfg;
    longint      env_lvl[CHANNELS];
    longint      hold_left[CHANNELS];
    longint      gain_now[CHANNELS];
    gated_beat_t pending_gated[$];
    int          errors;

    function new();
      cfg = '{RST_ATTACK, RST_RELEASE, RST_OPEN, RST_CLOSE, RST_FLOOR, RST_HOLD,
              RST_PUNCH, RST_MIX};
      for (int i = 0; i < CHANNELS; i++) begin
        env_lvl[i]   = 0;
        hold_left[i] = 0;
        gain_now[i]  = longint'(UNITY_GAIN);
      end
      errors = 0;
    endfunction

    // ties away from zero
    function longint round_shift(longint v, int n);
      longint mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (longint'(1) <<< (n - 1))) >>> n;
      return (v < 0) ? -mag : mag;
    endfunction

    function longint gain_step(longint diff, longint k);
      return (diff * k + 8388608) >>> 24;
    endfunction

    function void accept_sample(logic [CH_BITS-1:0] ch, logic signed [SAMPLE_BITS-1:0] audio,
                                logic signed [SAMPLE_BITS-1:0] key);
      longint      dry, lvl, coef, env, g, wet, res, mx, fl, hi;
      int          idx;
      gated_beat_t b;
      idx = (int'(ch) >= CHANNELS) ? CHANNELS - 1 : int'(ch);
      dry = audio;
      lvl = key;
      if (lvl < 0) lvl = -lvl;
      coef = (lvl > env_lvl[idx]) ? longint'(cfg.attack_coeff) : longint'(cfg.release_coeff);
      env = (coef * env_lvl[idx] + (longint'(16777216) - coef) * lvl + 8388608) >>> 24;
      if (env > 16777215) env = 16777215;
      env_lvl[idx] = env;

      g  = gain_now[idx];
      fl = longint'(cfg.floor_gain);
      if (env >= longint'(cfg.open_threshold)) begin
        hold_left[idx] = longint'(cfg.hold_length);
        g = longint'(cfg.punch_gain);
      end else if (hold_left[idx] > 0) begin
        hold_left[idx] = hold_left[idx] - 1;
      end else if (env <= longint'(cfg.close_threshold)) begin
        if (fl >= g) g = g + gain_step(fl - g, longint'(GLIDE_K));
        else g = g - gain_step(g - fl, longint'(GLIDE_K));
      end
      g = g & 16777215;

      wet = round_shift(dry * g, 22);
      mx  = longint'(cfg.mix_amount);
      if (mx > longint'(MIX_FULL)) mx = longint'(MIX_FULL);
      if (mx > longint'(MIX_BYPASS_LIMIT)) res = wet;
      else res = round_shift(wet * mx + dry * (longint'(MIX_FULL) - mx), 16);
      hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
      if (res > hi) res = hi;
      if (res < -hi - 1) res = -hi - 1;

      b.chan   = ch;
      b.sample = res[SAMPLE_BITS-1:0];
      b.gain   = g[GAIN_W-1:0];
      pending_gated = {pending_gated, b};

      if (g > longint'(UNITY_GAIN)) g = g - gain_step(g - longint'(UNITY_GAIN), longint'(DECAY_K));
      gain_now[idx] = g & 16777215;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_gated(logic [CH_BITS-1:0] ch, logic [SAMPLE_BITS-1:0] sample,
                     logic [GAIN_W-1:0] gain);
      gated_beat_t e;
      if (pending_gated.size() == 0) begin
        report($sformatf("result beat with nothing pending, ch=%0d", ch));
        return;
      end
      e = pending_gated.pop_front();
      if (ch !== e.chan)
        report($sformatf("channel_out got %0d exp %0d", ch, e.chan));
      if (sample !== e.sample)
        report($sformatf("gated_sample got %0d exp %0d", $signed(sample), $signed(e.sample)));
      if (gain !== e.gain)
        report($sformatf("gate_gain got %0d exp %0d", gain, e.gain));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  ngh_in_if  in_if();
  ngh_out_if out_if();

  gate_tracker sb;
  bit  calm = 1'b0;
  int  in_gap_pct = 20;
  int  out_stall_pct = 20;
  int  stall_left = 0;
  int  quiet_cycles = 0;
  bit  loud[CHANNELS];

  noise_gate_hold_punch_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // result side: check accepted beats, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready)
        sb.check_gated(out_if.channel_out, out_if.gated_sample, out_if.gate_gain);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < out_stall_pct) begin
        stall_left = $urandom_range(0, 7);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end else begin
      out_if.ready <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_sample(logic [CH_BITS-1:0] ch, logic signed [SAMPLE_BITS-1:0] audio,
                             logic signed [SAMPLE_BITS-1:0] key);
    if (!calm && $urandom_range(0, 99) < in_gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.channel_index <= ch;
    in_if.audio_sample  <= audio;
    in_if.key_sample    <= key;
    do @(posedge clk_i); while (!in_if.ready);
    sb.accept_sample(ch, audio, key);
  endtask

  task automatic apb_write(ngh_reg_e r, logic [APB_DW-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic load_config(ngh_cfg_t c);
    apb_write(REG_ATTACK,  APB_DW'(c.attack_coeff));
    apb_write(REG_RELEASE, APB_DW'(c.release_coeff));
    apb_write(REG_OPEN,    APB_DW'(c.open_threshold));
    apb_write(REG_CLOSE,   APB_DW'(c.close_threshold));
    apb_write(REG_FLOOR,   APB_DW'(c.floor_gain));
    apb_write(REG_HOLD,    APB_DW'(c.hold_length));
    apb_write(REG_PUNCH,   APB_DW'(c.punch_gain));
    apb_write(REG_MIX,     APB_DW'(c.mix_amount));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.cfg = c;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending_gated.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic ngh_cfg_t random_config();
    ngh_cfg_t c;
    c.attack_coeff  = COEFF_W'($urandom_range(0, 1) ? $urandom
                                                    : 24'hFFFFFF - $urandom_range(0, 400000));
    c.release_coeff = COEFF_W'($urandom_range(0, 1) ? $urandom
                                                    : 24'hFFFFFF - $urandom_range(0, 400000));
    c.open_threshold = ENV_W'($urandom_range(0, 8388608));
    c.close_threshold = ENV_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 8388608)
                                                           : $urandom_range(0, c.open_threshold));
    c.floor_gain  = FLOOR_W'(($urandom_range(0, 5) == 0) ? $urandom
                                                         : $urandom_range(0, 4194304));
    c.hold_length = HOLD_W'(($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 24));
    c.punch_gain  = GAIN_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 4194303)
                                                        : $urandom_range(4194304, 16777215));
    case ($urandom_range(0, 3))
      0: c.mix_amount = MIX_FULL;
      1: c.mix_amount = MIX_W'($urandom_range(0, 65536));
      2: c.mix_amount = MIX_W'($urandom_range(65460, 65536));
      default: c.mix_amount = MIX_W'($urandom_range(65537, 131071));
    endcase
    return c;
  endfunction

  task automatic run_directed();
    send_sample(0, 0, 0);
    send_sample(1, S_MAX, S_MIN);
    send_sample(0, S_MIN, S_MAX);
    repeat (4) send_sample(1, S_MAX, S_MIN);
    repeat (4) send_sample(0, S_MIN, S_MAX);
    send_sample(1, S_MIN, 0);
    send_sample(0, S_MAX, 0);
    send_sample(0, 1, 0);
    send_sample(1, -1, 0);
    send_sample(0, 2, 0);
    send_sample(1, -3, 0);
    send_sample(1, 24'sh555555, 24'shAAAAAA);
    send_sample(0, 24'shAAAAAA, 24'sh555555);
    send_sample(1, -1, -1);
    send_sample(0, 12345, -12345);
  endtask

  // mostly loud/quiet key bursts per channel, some noise and extremes
  task automatic run_random(int count);
    logic [CH_BITS-1:0]            ch;
    logic signed [SAMPLE_BITS-1:0] audio, key;
    int unsigned                   mag;
    for (int n = 0; n < count; n++) begin
      ch = CH_BITS'($urandom_range(0, CHANNELS - 1));
      if ($urandom_range(0, 11) == 0) loud[ch] = !loud[ch];
      audio = SAMPLE_BITS'($urandom);
      case ($urandom_range(0, 15))
        0: key = SAMPLE_BITS'($urandom);
        1: begin
          audio = S_MAX;
          key   = S_MIN;
        end
        2: begin
          audio = S_MIN;
          key   = S_MAX;
        end
        3: begin
          audio = 0;
          key   = SAMPLE_BITS'($urandom);
        end
        default: begin
          mag = loud[ch] ? $urandom_range(0, 8388607) : $urandom_range(0, 4095);
          key = SAMPLE_BITS'(mag);
          if ($urandom_range(0, 1)) key = -key;
        end
      endcase
      send_sample(ch, audio, key);
    end
  endtask

  initial begin
    ngh_cfg_t cfg;
    sb = new();
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.channel_index = '0;
    in_if.audio_sample  = '0;
    in_if.key_sample    = '0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    for (int p = 0; p < PHASES; p++) begin
      cfg = random_config();
      case (p)
        0: cfg = '{24'd0, 24'd0, 24'd8388608, 24'd8388608, 23'd0, 16'd0, 24'hFFFFFF, 17'd0};
        1: cfg = '{24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0, 23'd4194304, 16'hFFFF,
                   UNITY_GAIN, MIX_FULL};
        // close above open, punch below unity, mix above full
        2: cfg = '{24'd0, 24'd8388608, 24'd2000000, 24'd3000000, 23'h7FFFFF, 16'd3,
                   24'd3000000, 17'h1FFFF};
        3: begin
          cfg.mix_amount  = MIX_BYPASS_LIMIT;
          cfg.hold_length = 16'd4;
        end
        4: begin
          cfg.mix_amount  = MIX_BYPASS_LIMIT + 17'd1;
          cfg.hold_length = 16'd0;
        end
        default: ;
      endcase
      drain();
      load_config(cfg);
      calm          = (p == PHASES - 1);
      in_gap_pct    = calm ? 0 : 20 * $urandom_range(0, 2);
      out_stall_pct = calm ? 0 : 20 * $urandom_range(0, 2);
      run_random(ITEMS_PER_PHASE);
    end
    drain();

    if (sb.errors == 0 && sb.pending_gated.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
